@@ hw/rtl/pwq_pkg.sv @@
package pwq_pkg;

  localparam int PRIORITY_LEVELS = 16;
  localparam int THREAD_IDS = 32;

  localparam int OpWidth = 3;
  localparam int StatusWidth = 2;
  localparam int ThreadIdWidth = $clog2(THREAD_IDS);
  localparam int PriorityWidth = $clog2(PRIORITY_LEVELS);
  localparam int SwitchWidth = $clog2(PRIORITY_LEVELS + 1);

  localparam logic [OpWidth-1:0] OP_ENQUEUE  = 3'd0;
  localparam logic [OpWidth-1:0] OP_REMOVE   = 3'd1;
  localparam logic [OpWidth-1:0] OP_BLOCK    = 3'd2;
  localparam logic [OpWidth-1:0] OP_WAKE_ONE = 3'd3;
  localparam logic [OpWidth-1:0] OP_WAKE_ALL = 3'd4;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_MARK,
    CMD_POP
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

@@ hw/rtl/pwq_if.sv @@
interface pwq_req_if import pwq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OpWidth-1:0]       operation;
  logic [ThreadIdWidth-1:0] thread_id;
  logic [PriorityWidth-1:0] priority_req;

  modport source(output valid, operation, thread_id, priority_req, input ready);
  modport sink(input valid, operation, thread_id, priority_req, output ready);
endinterface

interface pwq_rsp_if import pwq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ThreadIdWidth-1:0] entry_id;
  logic                     has_entry;
  logic                     woken;
  logic [SwitchWidth-1:0]   switch_priority;
  logic [StatusWidth-1:0]   result_status;
  logic                     last;

  modport source(output valid, entry_id, has_entry, woken, switch_priority, result_status,
                 last, input ready);
  modport sink(input valid, entry_id, has_entry, woken, switch_priority, result_status,
               last, output ready);
endinterface

@@ hw/rtl/pwq_cell.sv @@
module pwq_cell import pwq_pkg::*; #(
  parameter int IdWidth = 5,
  parameter int PrioWidth = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_cmd_t            cmd,
  input  logic [IdWidth-1:0]   key_id,
  input  logic [PrioWidth-1:0] key_prio,
  input  logic                 left_after,
  input  logic                 left_occ,
  input  logic                 left_sleep,
  input  logic [IdWidth-1:0]   left_id,
  input  logic [PrioWidth-1:0] left_prio,
  input  logic                 right_occ,
  input  logic                 right_sleep,
  input  logic [IdWidth-1:0]   right_id,
  input  logic [PrioWidth-1:0] right_prio,
  input  logic                 hit_in,
  output logic                 occ,
  output logic                 sleep,
  output logic [IdWidth-1:0]   id,
  output logic [PrioWidth-1:0] prio,
  output logic                 after,
  output logic                 hit_out
);

  logic                 occ_next;
  logic                 sleep_next;
  logic [IdWidth-1:0]   id_next;
  logic [PrioWidth-1:0] prio_next;
  logic                 match;

  assign after   = occ && (prio <= key_prio);
  assign match   = occ && (id == key_id);
  assign hit_out = hit_in || match;

  always_comb begin
    occ_next   = occ;
    sleep_next = sleep;
    id_next    = id;
    prio_next  = prio;
    unique case (cmd)
      CMD_INSERT: begin
        if (!after) begin
          if (left_after) begin
            occ_next   = 1'b1;
            sleep_next = 1'b0;
            id_next    = key_id;
            prio_next  = key_prio;
          end else begin
            occ_next   = left_occ;
            sleep_next = left_sleep;
            id_next    = left_id;
            prio_next  = left_prio;
          end
        end
      end
      CMD_REMOVE, CMD_POP: begin
        if (cmd == CMD_POP || hit_out) begin
          occ_next   = right_occ;
          sleep_next = right_sleep;
          id_next    = right_id;
          prio_next  = right_prio;
        end
      end
      CMD_MARK: begin
        if (match && !hit_in) begin
          sleep_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= 1'b0;
      sleep <= 1'b0;
    end else begin
      occ   <= occ_next;
      sleep <= sleep_next;
    end
  end

  always_ff @(posedge clk) begin
    id   <= id_next;
    prio <= prio_next;
  end

endmodule

@@ hw/rtl/priority_wait_queue.sv @@
// Channel   Role   Payload
// request   sink   operation, thread_id, priority_req
// response  source entry_id, has_entry, woken, switch_priority, result_status, last
//
// A request is accepted in S_IDLE and applied to the cell row in S_EXEC. Unless stalled,
// a wake emits one response per cycle, one per entry popped, or one with no entry if empty.
// A new request is accepted while the previous response still waits in the output register.
// A stalled response holds the row; rst clears the occupancy and sleeping marks.
module priority_wait_queue import pwq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic     clk,
  input logic     rst,
  pwq_req_if.sink request,
  pwq_rsp_if.source response
);

  localparam int IdWidth = $clog2(THREAD_IDS);
  localparam int PrioWidth = $clog2(PRIORITY_LEVELS);
  localparam int HintWidth = $clog2(PRIORITY_LEVELS + 1);
  localparam logic [HintWidth-1:0] HintNone = HintWidth'(PRIORITY_LEVELS);

  state_t               state;
  state_t               state_next;
  logic [OpWidth-1:0]   op_q;
  logic [IdWidth-1:0]   id_q;
  logic [PrioWidth-1:0] prio_q;
  logic [HintWidth-1:0] hint;
  logic [HintWidth-1:0] hint_next;

  logic                 out_valid;
  logic [IdWidth-1:0]   out_id;
  logic                 out_has;
  logic                 out_woken;
  logic [HintWidth-1:0] out_hint;
  status_t              out_status;
  logic                 out_last;

  logic                 accept;
  logic                 fire;
  cell_cmd_t            cmd;
  logic [IdWidth-1:0]   res_id;
  logic                 res_has;
  logic                 res_woken;
  logic [HintWidth-1:0] res_hint;
  status_t              res_status;
  logic                 res_last;

  logic [QUEUE_DEPTH-1:0] occ_vec;
  logic [QUEUE_DEPTH-1:0] sleep_vec;
  logic [QUEUE_DEPTH-1:0] after_vec;
  logic [QUEUE_DEPTH-1:0] hit_vec;
  logic [IdWidth-1:0]     id_arr [QUEUE_DEPTH];
  logic [PrioWidth-1:0]   prio_arr [QUEUE_DEPTH];
  logic                   found;
  logic                   full;
  logic                   empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 l_after;
    logic                 l_occ;
    logic                 l_sleep;
    logic [IdWidth-1:0]   l_id;
    logic [PrioWidth-1:0] l_prio;
    logic                 l_hit;
    logic                 r_occ;
    logic                 r_sleep;
    logic [IdWidth-1:0]   r_id;
    logic [PrioWidth-1:0] r_prio;

    if (i == 0) begin : g_head
      assign l_after = 1'b1;
      assign l_occ   = 1'b0;
      assign l_sleep = 1'b0;
      assign l_id    = '0;
      assign l_prio  = '0;
      assign l_hit   = 1'b0;
    end else begin : g_mid
      assign l_after = after_vec[i-1];
      assign l_occ   = occ_vec[i-1];
      assign l_sleep = sleep_vec[i-1];
      assign l_id    = id_arr[i-1];
      assign l_prio  = prio_arr[i-1];
      assign l_hit   = hit_vec[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_occ   = 1'b0;
      assign r_sleep = 1'b0;
      assign r_id    = '0;
      assign r_prio  = '0;
    end else begin : g_body
      assign r_occ   = occ_vec[i+1];
      assign r_sleep = sleep_vec[i+1];
      assign r_id    = id_arr[i+1];
      assign r_prio  = prio_arr[i+1];
    end

    pwq_cell #(
      .IdWidth(IdWidth),
      .PrioWidth(PrioWidth)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .cmd(cmd),
      .key_id(id_q),
      .key_prio(prio_q),
      .left_after(l_after),
      .left_occ(l_occ),
      .left_sleep(l_sleep),
      .left_id(l_id),
      .left_prio(l_prio),
      .right_occ(r_occ),
      .right_sleep(r_sleep),
      .right_id(r_id),
      .right_prio(r_prio),
      .hit_in(l_hit),
      .occ(occ_vec[i]),
      .sleep(sleep_vec[i]),
      .id(id_arr[i]),
      .prio(prio_arr[i]),
      .after(after_vec[i]),
      .hit_out(hit_vec[i])
    );
  end

  assign found = hit_vec[QUEUE_DEPTH-1];
  assign full  = occ_vec[QUEUE_DEPTH-1];
  assign empty = !occ_vec[0];

  assign request.ready = (state == S_IDLE);
  assign accept = request.valid && request.ready;
  assign fire = (state == S_EXEC) && (!out_valid || response.ready);

  always_comb begin
    cmd        = CMD_HOLD;
    res_id     = id_q;
    res_has    = 1'b0;
    res_woken  = 1'b0;
    res_hint   = HintNone;
    res_status = ST_OK;
    res_last   = 1'b1;
    if (fire) begin
      unique case (op_q)
        OP_ENQUEUE: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            cmd = CMD_INSERT;
          end
        end
        OP_REMOVE: begin
          if (found) begin
            cmd = CMD_REMOVE;
          end else begin
            res_status = ST_NOT_FOUND;
          end
        end
        OP_BLOCK: begin
          if (found) begin
            cmd = CMD_MARK;
          end else if (full) begin
            res_status = ST_FULL;
          end else begin
            cmd = CMD_INSERT;
          end
        end
        OP_WAKE_ONE, OP_WAKE_ALL: begin
          if (!empty) begin
            cmd       = CMD_POP;
            res_id    = id_arr[0];
            res_has   = 1'b1;
            res_woken = sleep_vec[0];
            res_hint  = (sleep_vec[0] && hint == HintNone) ? HintWidth'(prio_arr[0]) : hint;
            res_last  = (op_q == OP_WAKE_ONE) || !occ_vec[1];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    hint_next  = hint;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
          hint_next  = HintNone;
        end
      end
      S_EXEC: begin
        if (fire) begin
          hint_next = res_hint;
          if (res_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hint <= hint_next;
    if (accept) begin
      op_q   <= request.operation;
      id_q   <= request.thread_id;
      prio_q <= request.priority_req;
    end
    if (fire) begin
      out_id     <= res_id;
      out_has    <= res_has;
      out_woken  <= res_woken;
      out_hint   <= res_hint;
      out_status <= res_status;
      out_last   <= res_last;
    end
  end

  assign response.valid           = out_valid;
  assign response.entry_id        = out_id;
  assign response.has_entry       = out_has;
  assign response.woken           = out_woken;
  assign response.switch_priority = out_hint;
  assign response.result_status   = out_status;
  assign response.last            = out_last;

  // Occupied cells always form an unbroken run from the head.
  a_packed: assert property (@(posedge clk) disable iff (rst)
    (occ_vec & (occ_vec + QUEUE_DEPTH'(1))) == '0)
    else $error("occupied cells are not contiguous from the head");

  for (genvar i = 1; i < QUEUE_DEPTH; i++) begin : g_sorted
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      occ_vec[i] |-> prio_arr[i-1] <= prio_arr[i])
      else $error("queue is out of priority order");
  end

  a_hint: assert property (@(posedge clk) disable iff (rst)
    fire && res_woken |-> res_hint != HintNone)
    else $error("woken entry without a switch hint");

  a_wake_all_empty: assert property (@(posedge clk) disable iff (rst)
    fire && res_has && res_last && op_q == OP_WAKE_ALL |=> empty)
    else $error("queue not empty after wake all");

endmodule
